/* src/lowest_free_id_allocator_core_assert.svh */
// Assertion macros for the lowest free id allocator.
`ifndef LOWEST_FREE_ID_ALLOCATOR_CORE_ASSERT_SVH
`define LOWEST_FREE_ID_ALLOCATOR_CORE_ASSERT_SVH

// Property holds at every clock edge out of reset.
`define LFIA_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("lowest free id allocator: assertion failed");

// Consequent holds in the cycle after the antecedent.
`define LFIA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lowest free id allocator: assertion failed");

`endif

/* src/lfia_pkg.sv */
package lfia_pkg;

    localparam int CMD_W   = 3;
    localparam int IDENT_W = 9;
    localparam int STAT_W  = 2;
    localparam int WORD_W  = 32;
    localparam int BIT_W   = 5;

    typedef enum logic [CMD_W-1:0] {
        CMD_ALLOC = 3'd0,
        CMD_REL   = 3'd1,
        CMD_CLAIM = 3'd2,
        CMD_QUERY = 3'd3,
        CMD_CLEAR = 3'd4
    } cmd_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2
    } stat_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOOK,
        S_MODIFY
    } state_t;

    typedef struct packed {
        logic load;
        logic look;
        logic commit;
        logic write;
    } ctl_cmd_t;

    typedef struct packed {
        logic need_rmw;
    } dp_stat_t;

endpackage

/* src/lowest_free_id_allocator_core.sv */
// Lowest-free identifier allocator for ids 1..MAX_IDS, kept as a bitmap of 32-bit
// words in a single-port-read word RAM plus one full mark per word in flops. One
// transaction at a time, in three steps (accept, full-mark search and word read,
// then modify and write-back), so a new transaction is taken only after the last
// has left the modify step, set by the read-modify-write of the word RAM. The result
// sits in an output register, loaded as the modify step commits; a stalled output
// holds the block in its last step until taken. Allocate returns the lowest free id,
// or status full when none is left. Reset and clear-all empty the set at once
// through per-word valid flops; there is no clearing pass.
module lowest_free_id_allocator_core #(
    parameter int MAX_IDS = 256
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [lfia_pkg::CMD_W-1:0]    cmd,
    input  logic [lfia_pkg::IDENT_W-1:0]  ident,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [lfia_pkg::IDENT_W-1:0]  granted_ident,
    output logic                          was_in_use,
    output logic [lfia_pkg::STAT_W-1:0]   status
);
    import lfia_pkg::*;

    ctl_cmd_t ctl;
    dp_stat_t stat;

    lfia_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .ctl       (ctl)
    );

    lfia_datapath #(
        .MAX_IDS (MAX_IDS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctl           (ctl),
        .stat          (stat),
        .cmd           (cmd),
        .ident         (ident),
        .granted_ident (granted_ident),
        .was_in_use    (was_in_use),
        .status        (status)
    );

endmodule

/* src/lfia_ram.sv */
module lfia_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 8,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* src/lfia_ctrl.sv */
module lfia_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    output logic              out_valid,
    input  logic              out_stall,
    input  lfia_pkg::dp_stat_t stat,
    output lfia_pkg::ctl_cmd_t ctl
);
    import lfia_pkg::*;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    assign out_free = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    ctl.load   = 1'b1;
                    state_next = S_LOOK;
                end
            end
            S_LOOK:
            begin
                ctl.look   = 1'b1;
                state_next = S_MODIFY;
            end
            S_MODIFY:
            begin
                if (out_free)
                begin
                    ctl.commit = 1'b1;
                    ctl.write  = stat.need_rmw;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (ctl.commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

/* src/lfia_datapath.sv */
module lfia_datapath #(
    parameter int MAX_IDS = 256
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  lfia_pkg::ctl_cmd_t            ctl,
    output lfia_pkg::dp_stat_t            stat,
    input  logic [lfia_pkg::CMD_W-1:0]    cmd,
    input  logic [lfia_pkg::IDENT_W-1:0]  ident,
    output logic [lfia_pkg::IDENT_W-1:0]  granted_ident,
    output logic                          was_in_use,
    output logic [lfia_pkg::STAT_W-1:0]   status
);
    import lfia_pkg::*;

    localparam int NWORDS     = (MAX_IDS + 31) / 32;
    localparam int WA_W       = (NWORDS > 1) ? $clog2(NWORDS) : 1;
    localparam int LAST_VALID = MAX_IDS - (NWORDS - 1) * 32;
    localparam logic [WORD_W-1:0] PAD_MASK =
        (LAST_VALID == 32) ? '0 : ~((WORD_W'(1) << LAST_VALID) - WORD_W'(1));
    localparam logic [WA_W-1:0] LAST_W = WA_W'(NWORDS - 1);

    cmd_t                cmd_reg;
    logic [IDENT_W-1:0]  ident_reg;
    logic [WA_W-1:0]     w_reg;
    logic [BIT_W-1:0]    bit_reg;
    logic                need_rmw_reg;
    logic [NWORDS-1:0]   mark_reg, mark_next;
    logic [NWORDS-1:0]   valid_reg, valid_next;
    logic [IDENT_W-1:0]  granted_reg;
    logic                was_reg;
    stat_t               status_reg;

    logic                any_free;
    logic [WA_W-1:0]     free_w;
    logic [IDENT_W-1:0]  pos;
    logic [WA_W-1:0]     ident_w;
    logic                range_ok;
    logic                need_rmw_c;

    logic [WORD_W-1:0]   rdata;
    logic [WORD_W-1:0]   word;
    logic [WORD_W-1:0]   occ;
    logic [WORD_W-1:0]   word_new;
    logic [BIT_W-1:0]    zb;
    logic [IDENT_W-1:0]  granted_c;
    logic                was_c;
    stat_t               status_c;

    // lowest word whose full mark is clear
    always_comb
    begin
        any_free = 1'b0;
        free_w   = '0;
        for (int i = NWORDS - 1; i >= 0; i--)
        begin
            if (!mark_reg[i])
            begin
                any_free = 1'b1;
                free_w   = WA_W'(i);
            end
        end
    end

    assign pos      = ident_reg - IDENT_W'(1);
    assign ident_w  = WA_W'(pos >> BIT_W);
    assign range_ok = (ident_reg != '0) && (32'(ident_reg) <= 32'(MAX_IDS));

    always_comb
    begin
        case (cmd_reg) inside
            CMD_ALLOC:                    need_rmw_c = any_free;
            CMD_REL, CMD_CLAIM, CMD_QUERY: need_rmw_c = range_ok;
            default:                      need_rmw_c = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mark_reg     <= '0;
            valid_reg    <= '0;
            need_rmw_reg <= 1'b0;
        end
        else
        begin
            mark_reg  <= mark_next;
            valid_reg <= valid_next;
            if (ctl.look)
            begin
                need_rmw_reg <= need_rmw_c;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            cmd_reg   <= cmd_t'(cmd);
            ident_reg <= ident;
        end
        if (ctl.look)
        begin
            w_reg   <= (cmd_reg == CMD_ALLOC) ? free_w : ident_w;
            bit_reg <= pos[BIT_W-1:0];
        end
        if (ctl.commit)
        begin
            granted_reg <= granted_c;
            was_reg     <= was_c;
            status_reg  <= status_c;
        end
    end

    lfia_ram #(
        .WIDTH (WORD_W),
        .DEPTH (NWORDS)
    ) u_words (
        .clk   (clk),
        .we    (ctl.write),
        .waddr (w_reg),
        .wdata (word_new),
        .re    (ctl.look && need_rmw_c),
        .raddr ((cmd_reg == CMD_ALLOC) ? free_w : ident_w),
        .rdata (rdata)
    );

    // never-written words read as empty
    assign word = valid_reg[w_reg] ? rdata : '0;
    assign occ  = word | ((w_reg == LAST_W) ? PAD_MASK : '0);

    always_comb
    begin
        zb = '0;
        for (int b = WORD_W - 1; b >= 0; b--)
        begin
            if (!occ[b])
            begin
                zb = BIT_W'(b);
            end
        end
    end

    always_comb
    begin
        granted_c = '0;
        was_c     = 1'b0;
        status_c  = ST_OK;
        word_new  = word;
        case (cmd_reg) inside
            CMD_ALLOC:
            begin
                if (need_rmw_reg)
                begin
                    granted_c = IDENT_W'((32'(w_reg) << BIT_W) + 32'(zb) + 32'd1);
                    word_new  = word | (WORD_W'(1) << zb);
                end
                else
                begin
                    status_c = ST_FULL;
                end
            end
            CMD_REL, CMD_CLAIM, CMD_QUERY:
            begin
                granted_c = ident_reg;
                if (need_rmw_reg)
                begin
                    was_c = word[bit_reg];
                    if (cmd_reg == CMD_REL)
                    begin
                        word_new = word & ~(WORD_W'(1) << bit_reg);
                    end
                    else if (cmd_reg == CMD_CLAIM)
                    begin
                        word_new = word | (WORD_W'(1) << bit_reg);
                    end
                end
                else
                begin
                    status_c = ST_RANGE;
                end
            end
            default:
            begin
                granted_c = '0;
            end
        endcase
    end

    always_comb
    begin
        mark_next  = mark_reg;
        valid_next = valid_reg;
        if (ctl.commit && (cmd_reg == CMD_CLEAR))
        begin
            mark_next  = '0;
            valid_next = '0;
        end
        else if (ctl.write)
        begin
            valid_next[w_reg] = 1'b1;
            mark_next[w_reg]  = &(word_new | ((w_reg == LAST_W) ? PAD_MASK : '0));
        end
    end

    assign stat.need_rmw = need_rmw_reg;
    assign granted_ident = granted_reg;
    assign was_in_use    = was_reg;
    assign status        = status_reg;

endmodule

/* src/lfia_checker.sv */
`include "lowest_free_id_allocator_core_assert.svh"

module lfia_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic                          in_stall,
    input  logic                          out_valid,
    input  logic                          out_stall,
    input  logic [lfia_pkg::IDENT_W-1:0]  granted_ident,
    input  logic                          was_in_use,
    input  logic [lfia_pkg::STAT_W-1:0]   status
);
    import lfia_pkg::*;

    // one transaction in flight: busy right after acceptance
    `LFIA_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && !in_stall, in_stall)

    `LFIA_ASSERT(a_full_is_empty, clk, rst_n,
        !(out_valid && (status == ST_FULL)) || ((granted_ident == '0) && !was_in_use))

    `LFIA_ASSERT(a_was_only_ok, clk, rst_n,
        !(out_valid && was_in_use) || (status == ST_OK))

    `LFIA_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall,
        out_valid && $stable(granted_ident) && $stable(was_in_use) && $stable(status))

endmodule

bind lowest_free_id_allocator_core lfia_checker u_checker (.*);
